// ===== rtl/core/sorted_key_table_core_assert.svh =====
// Assertion macros for the checker file of the sorted key table.
`ifndef SORTED_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("sorted key table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("sorted key table assertion failed");

`endif

// ===== rtl/core/skt_pkg.sv =====
package skt_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Cells are reduced in groups, one registered level per group
	localparam int GROUP_SIZE  = 16;
	localparam int LOC_W       = $clog2(GROUP_SIZE);
	localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_DEPTH   = NUM_GROUPS * GROUP_SIZE;

	// Fixed field widths
	localparam int KEY_W  = 32;
	localparam int PAY_W  = 32;
	localparam int POS_W  = 7;
	localparam int USED_W = 8;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_UPDATE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [POS_W-1:0]  position;
		logic [PAY_W-1:0]  payload_out;
		logic [USED_W-1:0] entries_used;
	} out_item_t;

	// Broadcast control to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic upd;
	} cell_ctrl_t;

	// Per-group search result
	typedef struct packed {
		logic             hit;
		logic             bnd;
		logic [LOC_W-1:0] loc;
		logic [PAY_W-1:0] pay;
	} group_res_t;

endpackage

// ===== rtl/core/sorted_key_table_core.sv =====
// One item at a time: a new transaction is accepted only after the last one
// has committed; compare in the cell row, group reduction, final merge and
// commit run in turn for a single item.
// A result held at the output stalls the next commit, not the next acceptance.
// Reset clears the entry count and the output valid; cell contents stay as
// they are and are only read below the entry count.
module sorted_key_table_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  skt_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output skt_pkg::out_item_t out_data
);
	import skt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_RED  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                            state_q;
	in_item_t                          req_q;
	logic [CNT_W-1:0]                  used_q;
	logic                              out_valid_q;
	out_item_t                         out_q;

	cell_ctrl_t                        ctrl;
	logic [TABLE_DEPTH-1:0][KEY_W-1:0] cell_key;
	logic [TABLE_DEPTH-1:0][PAY_W-1:0] cell_pay;
	logic [TABLE_DEPTH-1:0]            lt_s1;
	logic [TABLE_DEPTH-1:0]            eq_s1;
	logic [PAD_DEPTH-1:0]              bnd_pad;
	logic [PAD_DEPTH-1:0]              eq_pad;
	logic [PAD_DEPTH-1:0][PAY_W-1:0]   pay_pad;
	group_res_t                        grp_s2 [NUM_GROUPS];

	logic                              hit;
	logic [IDX_W-1:0]                  at;
	logic [PAY_W-1:0]                  found_pay;
	logic                              full;
	logic                              out_load;
	logic [CNT_W-1:0]                  used_next;
	out_item_t                         res;

	// Row of cells; cell 0 sees an always-below neighbour
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic                 occ;
		logic                 nb_lt;
		logic [KEY_W-1:0]     nb_key;
		logic [PAY_W-1:0]     nb_pay;

		assign occ = used_q > CNT_W'(i);
		if (i == 0) begin : g_first
			assign nb_lt  = 1'b1;
			assign nb_key = req_q.key;
			assign nb_pay = req_q.payload_in;
		end else begin : g_rest
			assign nb_lt  = lt_s1[i-1];
			assign nb_key = cell_key[i-1];
			assign nb_pay = cell_pay[i-1];
		end

		skt_cell u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.req_key      (req_q.key),
			.req_payload  (req_q.payload_in),
			.occupied     (occ),
			.prev_lt      (nb_lt),
			.prev_key     (nb_key),
			.prev_payload (nb_pay),
			.key_q        (cell_key[i]),
			.payload_q    (cell_pay[i]),
			.lt_s1        (lt_s1[i]),
			.eq_s1        (eq_s1[i])
		);
	end

	// Boundary of the below-key prefix marks the lower bound; pad to whole groups
	for (genvar j = 0; j < PAD_DEPTH; j++) begin : g_pad
		if (j >= TABLE_DEPTH) begin : g_none
			assign bnd_pad[j] = 1'b0;
			assign eq_pad[j]  = 1'b0;
			assign pay_pad[j] = '0;
		end else if (j == 0) begin : g_zero
			assign bnd_pad[j] = !lt_s1[j];
			assign eq_pad[j]  = eq_s1[j];
			assign pay_pad[j] = cell_pay[j];
		end else begin : g_mid
			assign bnd_pad[j] = !lt_s1[j] && lt_s1[j-1];
			assign eq_pad[j]  = eq_s1[j];
			assign pay_pad[j] = cell_pay[j];
		end
	end

	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		skt_group_reduce u_red (
			.clk    (clk),
			.bnd    (bnd_pad[g*GROUP_SIZE +: GROUP_SIZE]),
			.eq     (eq_pad[g*GROUP_SIZE +: GROUP_SIZE]),
			.pay    (pay_pad[g*GROUP_SIZE +: GROUP_SIZE]),
			.res_s2 (grp_s2[g])
		);
	end

	// Merge the group results
	always_comb begin
		hit       = 1'b0;
		at        = '0;
		found_pay = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (grp_s2[g].bnd) begin
				at = at | IDX_W'(g * GROUP_SIZE + int'(grp_s2[g].loc));
			end
			if (grp_s2[g].hit) begin
				hit       = 1'b1;
				found_pay = found_pay | grp_s2[g].pay;
			end
		end
	end

	assign full     = (used_q == CNT_W'(TABLE_DEPTH));
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Result and commit decision
	always_comb begin
		res              = '0;
		res.status       = ST_MISSING;
		ctrl             = '0;
		ctrl.cmp         = (state_q == S_CMP);
		used_next        = used_q;
		case (req_q.action)
			ACT_INSERT: begin
				if (hit) begin
					res.status   = ST_DUP;
					res.position = POS_W'(at);
				end else if (full) begin
					res.status   = ST_FULL;
				end else begin
					res.status   = ST_OK;
					res.position = POS_W'(at);
					ctrl.ins     = out_load;
					used_next    = used_q + CNT_W'(1);
				end
			end
			ACT_LOOKUP: begin
				if (hit) begin
					res.status      = ST_OK;
					res.position    = POS_W'(at);
					res.payload_out = found_pay;
				end
			end
			ACT_UPDATE: begin
				if (hit) begin
					res.status      = ST_OK;
					res.position    = POS_W'(at);
					res.payload_out = req_q.payload_in;
					ctrl.upd        = out_load;
				end
			end
			default: begin
			end
		endcase
		res.entries_used = USED_W'(used_next);
	end

	// Sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CMP;
				end
				S_CMP: state_q <= S_RED;
				S_RED: state_q <= S_FIN;
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
						used_q  <= used_next;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_data;
		if (out_load) out_q <= res;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/skt_cell.sv =====
module skt_cell (
	input  logic                      clk,
	input  skt_pkg::cell_ctrl_t       ctrl,
	input  logic [skt_pkg::KEY_W-1:0] req_key,
	input  logic [skt_pkg::PAY_W-1:0] req_payload,
	input  logic                      occupied,
	input  logic                      prev_lt,
	input  logic [skt_pkg::KEY_W-1:0] prev_key,
	input  logic [skt_pkg::PAY_W-1:0] prev_payload,
	output logic [skt_pkg::KEY_W-1:0] key_q,
	output logic [skt_pkg::PAY_W-1:0] payload_q,
	output logic                      lt_s1,
	output logic                      eq_s1
);
	import skt_pkg::*;

	// Compare against the request key; on insert either take the new entry
	// (first cell not below the key) or shift in the lower neighbour.
	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			lt_s1 <= occupied && (key_q < req_key);
			eq_s1 <= occupied && (key_q == req_key);
		end
		if (ctrl.ins) begin
			if (!lt_s1) begin
				if (prev_lt) begin
					key_q     <= req_key;
					payload_q <= req_payload;
				end else begin
					key_q     <= prev_key;
					payload_q <= prev_payload;
				end
			end
		end else if (ctrl.upd && eq_s1) begin
			payload_q <= req_payload;
		end
	end

endmodule

// ===== rtl/core/skt_group_reduce.sv =====
module skt_group_reduce (
	input  logic                                                clk,
	input  logic [skt_pkg::GROUP_SIZE-1:0]                      bnd,
	input  logic [skt_pkg::GROUP_SIZE-1:0]                      eq,
	input  logic [skt_pkg::GROUP_SIZE-1:0][skt_pkg::PAY_W-1:0]  pay,
	output skt_pkg::group_res_t                                 res_s2
);
	import skt_pkg::*;

	group_res_t res;

	// OR-reduce the one-hot boundary and match flags of this group
	always_comb begin
		res = '0;
		for (int i = 0; i < GROUP_SIZE; i++) begin
			if (bnd[i]) begin
				res.bnd = 1'b1;
				res.loc = res.loc | LOC_W'(i);
			end
			if (eq[i]) begin
				res.hit = 1'b1;
				res.pay = res.pay | pay[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res;
	end

endmodule

// ===== rtl/core/skt_port_checker.sv =====
`include "sorted_key_table_core_assert.svh"

module skt_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input skt_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input skt_pkg::out_item_t out_data
);
	import skt_pkg::*;

	// One item in flight: the input closes after each accepted transaction
	`SKT_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// Count never exceeds the table depth
	`SKT_ASSERT_IMP(a_count_bound, clk, arst_n, out_valid,
		out_data.entries_used <= USED_W'(TABLE_DEPTH))

	// A full report comes only with a full table and no position or payload
	`SKT_ASSERT_IMP(a_full_report, clk, arst_n, out_valid && out_data.status == ST_FULL,
		out_data.entries_used == USED_W'(TABLE_DEPTH) && out_data.position == '0 &&
		out_data.payload_out == '0)

	// Payload is only reported on success
	`SKT_ASSERT_IMP(a_payload_ok, clk, arst_n, out_valid && out_data.payload_out != '0,
		out_data.status == ST_OK)

	// A stalled result holds
	`SKT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data))

endmodule

bind sorted_key_table_core skt_port_checker u_skt_port_checker (.*);
